/* src/swm_pkg.sv */
// shared constants, types and state codes for the sliding-window median block
`default_nettype none
package swm_pkg;

	// parameter defaults
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int MEDIAN_BITS = 16;
	localparam int COST_BITS   = 22;
	localparam int CFG_BITS    = 7;

	// register file
	localparam int            APB_ADDR_BITS    = 3;
	localparam int            APB_DATA_BITS    = 32;
	localparam logic          REG_WINDOW_SIZE  = 1'b0;
	localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = 7'd3;

	// top-level sequencer
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_LOAD,
		TOP_SORT,
		TOP_OUT
	} top_state_t;

	// sorted-window pass engine
	typedef enum logic {
		SRT_IDLE,
		SRT_RUN
	} srt_state_t;

	// command into the sort engine
	typedef struct packed {
		logic go;
		logic remove;
		logic k_even;
	} sort_cmd_t;

	// status back from the sort engine
	typedef struct packed {
		logic busy;
		logic done;
	} sort_sts_t;

endpackage
`default_nettype wire

/* src/swm_ring.sv */
// arrival-order sample memory, one read and one write port, registered read
`default_nettype none
module swm_ring #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rd_addr,
	output logic [SAMPLE_BITS-1:0] rd_data,
	input  logic                   wr_en,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] wr_addr,
	input  logic [SAMPLE_BITS-1:0] wr_data
);
	import swm_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

	// read old data on a same-address write
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* src/swm_sort.sv */
// sorted window memory with a one-pass remove/insert merge and cost accumulation
`default_nettype none
module swm_sort #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swm_pkg::sort_cmd_t                cmd,
	input  logic [SAMPLE_BITS-1:0]            ins_val,
	input  logic [SAMPLE_BITS-1:0]            old_val,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   n_in,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   n_out,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   mid_idx,
	output swm_pkg::sort_sts_t                sts,
	output logic [SAMPLE_BITS-1:0]            med,
	output logic [swm_pkg::COST_BITS-1:0]     cost
);
	import swm_pkg::*;

	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	srt_state_t             state_q;
	srt_state_t             state_nx;
	logic                   done_q;
	logic [KW-1:0]          r_q;
	logic [KW-1:0]          w_q;
	logic                   removed_q;
	logic                   placed_q;
	logic [SAMPLE_BITS-1:0] ins_q;
	logic [SAMPLE_BITS-1:0] old_q;
	logic [KW-1:0]          n_in_q;
	logic [KW-1:0]          n_out_q;
	logic [KW-1:0]          mid_q;
	logic                   keven_q;
	logic [COST_BITS-1:0]   lo_q;
	logic [COST_BITS-1:0]   hi_q;
	logic [SAMPLE_BITS-1:0] med_q;

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] rd_q;

	logic                   hv;
	logic                   skip;
	logic                   place;
	logic                   emit_hd;
	logic                   out_en;
	logic                   consume;
	logic                   finish;
	logic [SAMPLE_BITS-1:0] out_val;
	logic [KW-1:0]          r_next;
	logic [AW-1:0]          rd_addr;
	logic [COST_BITS-1:0]   out_ext;

	// merge decision: drop the leaving sample once, slot the new one in order
	always_comb begin
		hv      = (r_q < n_in_q);
		skip    = !removed_q && hv && (rd_q == old_q);
		place   = !skip && !placed_q && (!hv || (ins_q <= rd_q));
		emit_hd = !skip && !place && hv;
		out_en  = (state_q == SRT_RUN) && (place || emit_hd);
		consume = (state_q == SRT_RUN) && (skip || emit_hd);
		out_val = place ? ins_q : rd_q;
		out_ext = COST_BITS'(out_val);
		r_next  = r_q + KW'(consume);
		rd_addr = (state_q == SRT_RUN) ? r_next[AW-1:0] : '0;
		finish  = (state_q == SRT_RUN) &&
			((out_en && (w_q == n_out_q - KW'(1))) || (!out_en && !skip));
	end

	// sorted memory, read ahead of the write pointer
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (out_en) begin
			mem[w_q[AW-1:0]] <= out_val;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SRT_IDLE: begin
				if (cmd.go) begin
					state_nx = SRT_RUN;
				end
			end
			SRT_RUN: begin
				if (finish) begin
					state_nx = SRT_IDLE;
				end
			end
			default: state_nx = SRT_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SRT_IDLE;
			done_q    <= 1'b0;
			r_q       <= '0;
			w_q       <= '0;
			removed_q <= 1'b1;
			placed_q  <= 1'b1;
		end else begin
			state_q <= state_nx;
			done_q  <= finish;
			if (state_q == SRT_IDLE && cmd.go) begin
				r_q       <= '0;
				w_q       <= '0;
				removed_q <= !cmd.remove;
				placed_q  <= 1'b0;
			end else if (state_q == SRT_RUN) begin
				r_q <= r_next;
				if (out_en) begin
					w_q <= w_q + KW'(1);
				end
				if (skip) begin
					removed_q <= 1'b1;
				end
				if (place) begin
					placed_q <= 1'b1;
				end
			end
		end
	end

	// pass operands and running sums below and above the median slot
	always_ff @(posedge clk) begin
		if (state_q == SRT_IDLE && cmd.go) begin
			ins_q   <= ins_val;
			old_q   <= old_val;
			n_in_q  <= n_in;
			n_out_q <= n_out;
			mid_q   <= mid_idx;
			keven_q <= cmd.k_even;
			lo_q    <= '0;
			hi_q    <= '0;
		end else if (out_en) begin
			if (w_q < mid_q) begin
				lo_q <= lo_q + out_ext;
			end else if (w_q == mid_q) begin
				med_q <= out_val;
			end else begin
				hi_q <= hi_q + out_ext;
			end
		end
	end

	// sum of |v - med| over a sorted window, the even case has one extra entry above
	always_comb begin
		med      = med_q;
		cost     = hi_q - lo_q - (keven_q ? COST_BITS'(med_q) : '0);
		sts.busy = (state_q == SRT_RUN);
		sts.done = done_q;
	end

	// write pointer never passes the read pointer
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_en |-> (w_q <= r_next))
		else $error("sorted write overtakes unread entry");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == SRT_RUN))
		else $error("done without a pass");

	a_w_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SRT_RUN) |-> (w_q < n_out_q))
		else $error("write index past window");

endmodule
`default_nettype wire

/* src/sliding_window_median_cost.sv */
// sliding-window lower median and absolute-deviation cost, top level
//
// samples arrive on the sample channel (sample_valid / sample_stall); each
// word is taken when valid is high and stall is low. once the window holds
// window_size samples, each sample yields one result word on the result
// channel (result_valid / result_stall): the lower median of the window and
// the sum of absolute differences from it. samples before the window fills
// yield nothing.
// a sample passes from acceptance through the LOAD and SORT states (and OUT
// when it yields a result) to its result in the output register, and the next
// sample is taken only once the block is back in IDLE: LOAD reads the leaving
// sample from the ring memory, then one pass walks the sorted-window memory,
// removing the leaving sample, inserting the new one and summing.
// sample_stall stays high while a sample is in work. a finished result sits
// in the output register; while the receiver stalls the next sample is still
// taken and worked, and only its result waits for the register to free.
// reset empties the window and sets window_size to 3; writing window_size
// over the register port also empties the window. memories need no clearing.
`default_nettype none
module sliding_window_median_cost #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [swm_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [swm_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready,
	// sample channel
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic [SAMPLE_BITS-1:0]                sample,
	// result channel
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [swm_pkg::MEDIAN_BITS-1:0]       median,
	output logic [swm_pkg::COST_BITS-1:0]         cost
);
	import swm_pkg::*;

	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = (KW > CFG_BITS) ? KW : CFG_BITS;

	top_state_t             state_q;
	top_state_t             state_nx;
	logic [CFG_BITS-1:0]    ws_q;
	logic [KW-1:0]          fill_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          slot_q;
	logic                   full_q;
	logic                   emit_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   res_valid_q;
	logic [MEDIAN_BITS-1:0] median_q;
	logic [COST_BITS-1:0]   cost_q;

	logic [CW-1:0]          ws_ext;
	logic [CW-1:0]          k_sat;
	logic [KW-1:0]          k;
	logic [KW-1:0]          mid;
	logic                   full;
	logic [AW-1:0]          slot;
	logic [KW-1:0]          ptr_inc;
	logic [AW-1:0]          ptr_next;
	logic                   cfg_wr;
	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic                   ring_we;
	logic [SAMPLE_BITS-1:0] ring_rd;
	sort_cmd_t              eng_cmd;
	sort_sts_t              eng_sts;
	logic [SAMPLE_BITS-1:0] eng_med;
	logic [COST_BITS-1:0]   eng_cost;
	logic [KW-1:0]          n_in;
	logic [KW-1:0]          n_out;

	// effective window length, zero taken as one and clipped to the memory depth
	always_comb begin
		ws_ext = CW'(ws_q);
		if (ws_ext == '0) begin
			k_sat = CW'(1);
		end else if (ws_ext > CW'(WINDOW_MAX)) begin
			k_sat = CW'(WINDOW_MAX);
		end else begin
			k_sat = ws_ext;
		end
		k        = k_sat[KW-1:0];
		mid      = (k - KW'(1)) >> 1;
		full     = (fill_q == k);
		slot     = full ? ptr_q : fill_q[AW-1:0];
		ptr_inc  = KW'(ptr_q) + KW'(1);
		ptr_next = (ptr_inc >= k) ? '0 : ptr_inc[AW-1:0];
		n_in     = full_q ? k : fill_q;
		n_out    = full_q ? k : fill_q + KW'(1);
	end

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_BITS'(ws_q) : '0;

	// handshakes
	assign out_free     = !res_valid_q || !result_stall;
	assign in_acc       = sample_valid && !sample_stall;
	assign result_valid = res_valid_q;
	assign median       = median_q;
	assign cost         = cost_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (sample_valid) begin
					state_nx = TOP_LOAD;
				end
			end
			TOP_LOAD: state_nx = TOP_SORT;
			TOP_SORT: begin
				if (eng_sts.done) begin
					state_nx = emit_q ? TOP_OUT : TOP_IDLE;
				end
			end
			TOP_OUT: begin
				if (out_free) begin
					state_nx = TOP_IDLE;
				end
			end
			default: state_nx = TOP_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_stall   = (state_q != TOP_IDLE);
		ring_we        = (state_q == TOP_LOAD);
		eng_cmd.go     = (state_q == TOP_LOAD);
		eng_cmd.remove = full_q;
		eng_cmd.k_even = !k[0];
		out_load       = (state_q == TOP_OUT) && out_free;
	end

	// control state, window bookkeeping and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_IDLE;
			ws_q        <= WINDOW_SIZE_RST;
			fill_q      <= '0;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr && paddr[2] == REG_WINDOW_SIZE) begin
				ws_q   <= pwdata[CFG_BITS-1:0];
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (state_q == TOP_LOAD) begin
				if (full_q) begin
					ptr_q <= ptr_next;
				end else begin
					fill_q <= fill_q + KW'(1);
				end
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// accepted word and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
			slot_q   <= slot;
			full_q   <= full;
			emit_q   <= full || (fill_q + KW'(1) == k);
		end
		if (out_load) begin
			median_q <= MEDIAN_BITS'(eng_med);
			cost_q   <= eng_cost;
		end
	end

	// arrival-order store
	swm_ring #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.rd_addr (slot),
		.rd_data (ring_rd),
		.wr_en   (ring_we),
		.wr_addr (slot_q),
		.wr_data (sample_q)
	);

	// sorted store and cost pass
	swm_sort #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (eng_cmd),
		.ins_val (sample_q),
		.old_val (ring_rd),
		.n_in    (n_in),
		.n_out   (n_out),
		.mid_idx (mid),
		.sts     (eng_sts),
		.med     (eng_med),
		.cost    (eng_cost)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k)
		else $error("fill count above window length");

	a_done_in_sort: assert property (@(posedge clk) disable iff (!arst_n)
		eng_sts.done |-> (state_q == TOP_SORT))
		else $error("sort pass finished outside sort state");

	a_sort_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TOP_SORT) |-> (eng_sts.busy || eng_sts.done))
		else $error("waiting on an idle sort engine");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result_valid)
		else $error("result not presented after load");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// self-checking bench for the sliding-window median and absolute-deviation cost block
`timescale 1ns / 1ps
module tb_top;

	localparam int K_MAX    = swm_pkg::WINDOW_MAX_DEF;
	localparam int SAMPLE_W = swm_pkg::SAMPLE_BITS_DEF;
	localparam int SETTLE_CYCLES = K_MAX + 16;
	localparam logic [swm_pkg::APB_ADDR_BITS-1:0] WINDOW_SIZE_ADDR =
		{swm_pkg::REG_WINDOW_SIZE, 2'b00};

	typedef struct packed {
		logic [swm_pkg::MEDIAN_BITS-1:0] median;
		logic [swm_pkg::COST_BITS-1:0]   cost;
	} median_cost_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [swm_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [swm_pkg::APB_DATA_BITS-1:0] pwdata = '0;
	logic [swm_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [swm_pkg::MEDIAN_BITS-1:0] median;
	logic [swm_pkg::COST_BITS-1:0] cost;

	sliding_window_median_cost dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.median       (median),
		.cost         (cost)
	);

	// predictor state: window in arrival order and sorted, fill level, oldest slot
	logic [SAMPLE_W-1:0] arrival_ring [K_MAX];
	logic [SAMPLE_W-1:0] sorted_ring [K_MAX];
	int unsigned held_count = 0;
	int unsigned oldest_slot = 0;
	logic [swm_pkg::CFG_BITS-1:0] window_size_reg = swm_pkg::WINDOW_SIZE_RST;

	logic [SAMPLE_W-1:0] sample_backlog [$];
	median_cost_t median_cost_q [$];
	median_cost_t fresh_result;
	median_cost_t want;

	int queued_count = 0;
	int accepted_count = 0;
	int result_count = 0;
	int fail_count = 0;
	int settings_used = 1;
	int send_gap = 0;
	int stall_gap = 0;
	int send_odds = 0;
	int stall_odds = 0;
	bit calm = 1'b0;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("sliding_window_median_cost: mismatch");
		$finish;
	end

	// window size register write: clears the window
	function automatic void load_window_size(input logic [swm_pkg::CFG_BITS-1:0] value);
		window_size_reg = value;
		held_count = 0;
		oldest_slot = 0;
	endfunction

	// insert into the first n sorted entries
	function automatic void sorted_put(input int unsigned n, input logic [SAMPLE_W-1:0] s);
		int unsigned i;
		i = n;
		while (i > 0 && sorted_ring[i-1] > s) begin
			sorted_ring[i] = sorted_ring[i-1];
			i--;
		end
		sorted_ring[i] = s;
	endfunction

	// advance the window by one sample; returns 1 when a result word is due
	function automatic bit slide_window(input logic [SAMPLE_W-1:0] s, output median_cost_t res);
		int unsigned k, p, i;
		int unsigned total;
		logic [SAMPLE_W-1:0] leaving, mid;
		k = (window_size_reg == 0) ? 1 :
			(window_size_reg > K_MAX) ? K_MAX : int'(window_size_reg);
		res = '0;
		if (held_count < k) begin
			arrival_ring[held_count] = s;
			sorted_put(held_count, s);
			held_count++;
			if (held_count < k) return 1'b0;
		end else begin
			p = (oldest_slot >= k) ? 0 : oldest_slot;
			leaving = arrival_ring[p];
			i = 0;
			while (i < k && sorted_ring[i] != leaving) i++;
			for (; i + 1 < k; i++) sorted_ring[i] = sorted_ring[i+1];
			sorted_put(k - 1, s);
			arrival_ring[p] = s;
			p++;
			oldest_slot = (p >= k) ? 0 : p;
		end
		mid = sorted_ring[(k + 1) / 2 - 1];
		total = 0;
		for (i = 0; i < k; i++)
			total += (sorted_ring[i] >= mid) ? sorted_ring[i] - mid : mid - sorted_ring[i];
		res.median = mid;
		res.cost = total[swm_pkg::COST_BITS-1:0];
		return 1'b1;
	endfunction

	// random sample: mostly full range, some clustered, extremes and heavy duplicates
	function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [SAMPLE_W-1:0] base);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5: return base + SAMPLE_W'($urandom_range(0, 15));
			6: return $urandom_range(0, 1) ? '1 : '0;
			default: return SAMPLE_W'($urandom_range(0, 3));
		endcase
	endfunction

	// sample driver: predicts on each accepted word, then presents the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				if (slide_window(sample, fresh_result))
					median_cost_q = {median_cost_q, fresh_result};
				accepted_count++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (!calm && send_odds != 0 && $urandom_range(1, 4 * send_odds) == 1) begin
					send_gap = $urandom_range(0, 5);
					sample_valid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					sample_valid <= 1'b1;
					sample <= sample_backlog.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				result_count++;
				if (median_cost_q.size() == 0) begin
					$error("unexpected result word: median %0d cost %0d", median, cost);
					fail_count++;
				end else begin
					want = median_cost_q.pop_front();
					if (median !== want.median) begin
						$error("median: expected %0d, got %0d", want.median, median);
						fail_count++;
					end
					if (cost !== want.cost) begin
						$error("cost: expected %0d, got %0d", want.cost, cost);
						fail_count++;
					end
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				result_stall <= 1'b1;
			end else if (!calm && stall_odds != 0 && $urandom_range(1, 4 * stall_odds) == 1) begin
				stall_gap = $urandom_range(0, 5);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// register write: setup then access cycle
	task automatic write_window_size(input logic [swm_pkg::APB_DATA_BITS-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_SIZE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		load_window_size(value[swm_pkg::CFG_BITS-1:0]);
		settings_used++;
	endtask

	task automatic feed(input logic [SAMPLE_W-1:0] s);
		sample_backlog = {sample_backlog, s};
		queued_count++;
	endtask

	// hold off until every word is taken and every result is back, then let the block go idle
	task automatic settle();
		while (accepted_count != queued_count || median_cost_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [swm_pkg::APB_DATA_BITS-1:0] wsize, input int count);
		logic [SAMPLE_W-1:0] base;
		write_window_size(wsize);
		base = SAMPLE_W'($urandom);
		send_odds = $urandom_range(0, 3);
		stall_odds = $urandom_range(0, 3);
		repeat (count) feed(draw_sample(base));
		settle();
	endtask

	// stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_odds = 2;
		stall_odds = 2;

		// reset window size of 3: extremes and repeated values
		feed('0); feed('1); feed(16'h8000); feed('1);
		feed('0); feed(16'h0007); feed(16'h0007); feed(16'h0001);
		settle();
		// size zero acts as a window of one
		write_window_size(32'd0);
		feed('1); feed('0); feed(16'h5555); feed(16'hAAAA);
		settle();
		// even window: lower median
		write_window_size(32'd2);
		feed(16'h0010); feed(16'h0004); feed(16'h0004);
		feed('1); feed('0); feed(16'h7FFF);
		settle();

		// random part: full and saturated windows, masked upper data bits, random sizes
		run_phase(32'd64, 260);
		run_phase(32'd127, 90);
		run_phase(32'hA5A5_A585, 100);
		run_phase(32'd0, 60);
		run_phase(32'd65, 90);
		repeat (5) run_phase(32'($urandom_range(1, K_MAX)), 100);
		run_phase(32'd1, 80);
		calm = 1'b1;
		run_phase(32'($urandom_range(2, 16)), 170);

		$display("covered %0d samples and %0d result words over %0d window size settings",
			accepted_count, result_count, settings_used);
		$display("window sizes included zero, one, two, the maximum and saturated values");
		if (fail_count == 0) begin
			$display("sliding_window_median_cost: match");
		end else begin
			$display("sliding_window_median_cost: mismatch");
		end
		$finish;
	end

endmodule
